### rtl/lpht_pkg.sv
// shared types and constants for the linear probe hash table
`timescale 1ns / 1ps
package lpht_pkg;

	// table size is a power of two, so the home slot is the low key bits
	localparam int SLOT_BITS   = 13;
	localparam int TABLE_SLOTS = 2 ** SLOT_BITS;
	localparam int KEY_BITS    = 22;
	localparam int VALUE_BITS  = 13;
	localparam int ENTRY_BITS  = 1 + KEY_BITS + VALUE_BITS;

	typedef logic [SLOT_BITS-1:0]  slot_t;
	typedef logic [KEY_BITS-1:0]   key_t;
	typedef logic [VALUE_BITS-1:0] value_t;

	typedef logic [1:0] action_t;
	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_FIND   = 2'd1;
	localparam action_t ACT_CLEAR  = 2'd2;

	typedef logic [2:0] status_t;
	localparam status_t ST_INSERTED = 3'd0;
	localparam status_t ST_FULL     = 3'd1;
	localparam status_t ST_FOUND    = 3'd2;
	localparam status_t ST_MISSING  = 3'd3;
	localparam status_t ST_CLEARED  = 3'd4;

	typedef struct packed {
		logic   used;
		key_t   key;
		value_t value;
	} entry_t;

endpackage

### rtl/lpht_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/linear_probe_hash_table.sv
// linear probing hash table top level: sequencer around one entry ram
//
// channel  direction  handshake            fields
// req      input      req_valid/req_stall  action, key, value
// rsp      output     rsp_valid/rsp_stall  status, found_value
//
// insert and find read one ram slot per probe, then emit the result; an unused
// action code goes straight to emit and reports missing.
// a clear sweeps every slot, one per cycle, then emits a cleared result.
// after reset the same sweep runs with req_stall high and emits no result.
// req_stall is high whenever the sequencer is busy; a waiting result sits in
// the rsp register, so the next item is taken while rsp_stall holds it.
`timescale 1ns / 1ps
module linear_probe_hash_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [1:0]                     action,
	input  logic [lpht_pkg::KEY_BITS-1:0]  key,
	input  logic [lpht_pkg::VALUE_BITS-1:0] value,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [2:0]                     status,
	output logic [lpht_pkg::VALUE_BITS-1:0] found_value
);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_PROBE, S_EMIT} state_t;

	state_t             state_q;
	lpht_pkg::slot_t    clr_addr_q;
	logic               clr_report_q;
	lpht_pkg::action_t  op_q;
	lpht_pkg::key_t     key_q;
	lpht_pkg::value_t   value_q;
	lpht_pkg::slot_t    probe_addr_q;
	lpht_pkg::slot_t    probe_cnt_q;
	lpht_pkg::status_t  pend_status_q;
	lpht_pkg::value_t   pend_value_q;
	logic               rsp_valid_q;
	lpht_pkg::status_t  status_q;
	lpht_pkg::value_t   found_value_q;

	logic                             accept;
	logic                             rsp_free;
	logic                             key_hit;
	logic                             last_probe;
	logic                             probe_done;
	logic                             ins_write;
	lpht_pkg::entry_t                 rd_entry;
	lpht_pkg::entry_t                 wr_entry;
	logic                             ram_we;
	lpht_pkg::slot_t                  ram_waddr;
	lpht_pkg::slot_t                  ram_raddr;
	logic [lpht_pkg::ENTRY_BITS-1:0]  ram_rdata;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// ram data belongs to probe_addr_q while probing
	assign rd_entry   = lpht_pkg::entry_t'(ram_rdata);
	assign key_hit    = (rd_entry.key == key_q);
	assign last_probe = (probe_cnt_q == lpht_pkg::slot_t'(lpht_pkg::TABLE_SLOTS - 1));
	assign probe_done = (state_q == S_PROBE) && (!rd_entry.used || last_probe ||
		((op_q == lpht_pkg::ACT_FIND) && key_hit));
	assign ins_write  = (state_q == S_PROBE) && (op_q == lpht_pkg::ACT_INSERT) &&
		!rd_entry.used;

	always_comb begin
		wr_entry       = '0;
		if (state_q != S_CLEAR) begin
			wr_entry.used  = 1'b1;
			wr_entry.key   = key_q;
			wr_entry.value = value_q;
		end
	end

	assign ram_we    = (state_q == S_CLEAR) || ins_write;
	assign ram_waddr = (state_q == S_CLEAR) ? clr_addr_q : probe_addr_q;
	// next probe is fetched ahead; unused when the current probe ends the search
	assign ram_raddr = (state_q == S_PROBE) ? probe_addr_q + lpht_pkg::slot_t'(1)
		: key[lpht_pkg::SLOT_BITS-1:0];

	lpht_ram #(
		.WIDTH (lpht_pkg::ENTRY_BITS),
		.DEPTH (lpht_pkg::TABLE_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_addr_q    <= '0;
			clr_report_q  <= 1'b0;
			op_q          <= lpht_pkg::ACT_INSERT;
			key_q         <= '0;
			value_q       <= '0;
			probe_addr_q  <= '0;
			probe_cnt_q   <= '0;
			pend_status_q <= lpht_pkg::ST_INSERTED;
			pend_value_q  <= '0;
			rsp_valid_q   <= 1'b0;
			status_q      <= lpht_pkg::ST_INSERTED;
			found_value_q <= '0;
		end else begin
			// an emit in the same cycle reloads the register instead
			if (rsp_valid_q && !rsp_stall && (state_q != S_EMIT)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + lpht_pkg::slot_t'(1);
					if (clr_addr_q == lpht_pkg::slot_t'(lpht_pkg::TABLE_SLOTS - 1)) begin
						if (clr_report_q) begin
							pend_status_q <= lpht_pkg::ST_CLEARED;
							pend_value_q  <= '0;
							state_q       <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q         <= action;
						key_q        <= key;
						value_q      <= value;
						probe_addr_q <= key[lpht_pkg::SLOT_BITS-1:0];
						probe_cnt_q  <= '0;
						unique case (action)
							lpht_pkg::ACT_INSERT, lpht_pkg::ACT_FIND: begin
								state_q <= S_PROBE;
							end
							lpht_pkg::ACT_CLEAR: begin
								clr_addr_q   <= '0;
								clr_report_q <= 1'b1;
								state_q      <= S_CLEAR;
							end
							default: begin
								pend_status_q <= lpht_pkg::ST_MISSING;
								pend_value_q  <= '0;
								state_q       <= S_EMIT;
							end
						endcase
					end
				end
				S_PROBE: begin
					if (probe_done) begin
						if (op_q == lpht_pkg::ACT_INSERT) begin
							pend_status_q <= rd_entry.used ? lpht_pkg::ST_FULL
								: lpht_pkg::ST_INSERTED;
							pend_value_q  <= '0;
						end else if (rd_entry.used && key_hit) begin
							pend_status_q <= lpht_pkg::ST_FOUND;
							pend_value_q  <= rd_entry.value;
						end else begin
							pend_status_q <= lpht_pkg::ST_MISSING;
							pend_value_q  <= '0;
						end
						state_q <= S_EMIT;
					end else begin
						probe_addr_q <= probe_addr_q + lpht_pkg::slot_t'(1);
						probe_cnt_q  <= probe_cnt_q + lpht_pkg::slot_t'(1);
					end
				end
				S_EMIT: begin
					if (rsp_free) begin
						rsp_valid_q   <= 1'b1;
						status_q      <= pend_status_q;
						found_value_q <= pend_value_q;
						state_q       <= S_IDLE;
					end
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign found_value = found_value_q;

endmodule

### tb/linear_probe_hash_table_test.sv
// self-checking testbench for the linear probe hash table
`timescale 1ns / 1ps
module linear_probe_hash_table_test;

	localparam lpht_pkg::action_t ACT_UNUSED = 2'd3;
	localparam int HI_BITS = lpht_pkg::KEY_BITS - lpht_pkg::SLOT_BITS;
	localparam int RANDOM_ITEMS = 1834;
	localparam int LONG_HOLD = 400;
	// slowest item is a clear sweep, plus the long rsp hold
	localparam int IDLE_LIMIT = 40000;

	typedef struct {
		lpht_pkg::status_t status;
		lpht_pkg::value_t  found_value;
	} outcome_t;

	class probe_table_scoreboard;
		bit                 occupied [lpht_pkg::TABLE_SLOTS];
		lpht_pkg::key_t     stored_key [lpht_pkg::TABLE_SLOTS];
		lpht_pkg::value_t   stored_value [lpht_pkg::TABLE_SLOTS];
		outcome_t           pending_outcomes[$];
		int                 errors;

		function new();
			foreach (occupied[i]) occupied[i] = 1'b0;
			errors = 0;
		endfunction

		function int outstanding();
			return pending_outcomes.size();
		endfunction

		// walk the probe sequence for an accepted item and queue its outcome
		function void note_request(lpht_pkg::action_t act, lpht_pkg::key_t k,
			lpht_pkg::value_t v);
			lpht_pkg::slot_t h;
			outcome_t        o;
			h = lpht_pkg::slot_t'(k % lpht_pkg::TABLE_SLOTS);
			o.status = lpht_pkg::ST_MISSING;
			o.found_value = '0;
			case (act)
				lpht_pkg::ACT_INSERT: begin
					o.status = lpht_pkg::ST_FULL;
					for (int n = 0; n < lpht_pkg::TABLE_SLOTS; n++) begin
						if (!occupied[h]) begin
							occupied[h] = 1'b1;
							stored_key[h] = k;
							stored_value[h] = v;
							o.status = lpht_pkg::ST_INSERTED;
							break;
						end
						h = h + 1'b1;
					end
				end
				lpht_pkg::ACT_FIND: begin
					for (int n = 0; n < lpht_pkg::TABLE_SLOTS; n++) begin
						if (!occupied[h])
							break;
						if (stored_key[h] == k) begin
							o.status = lpht_pkg::ST_FOUND;
							o.found_value = stored_value[h];
							break;
						end
						h = h + 1'b1;
					end
				end
				lpht_pkg::ACT_CLEAR: begin
					foreach (occupied[i]) occupied[i] = 1'b0;
					o.status = lpht_pkg::ST_CLEARED;
				end
				default: ;
			endcase
			pending_outcomes.push_back(o);
		endfunction

		function void check_outcome(lpht_pkg::status_t st, lpht_pkg::value_t fv);
			outcome_t o;
			if (pending_outcomes.size() == 0) begin
				$error("result with nothing expected: status=%0d found_value=%0d", st, fv);
				errors++;
				return;
			end
			o = pending_outcomes.pop_front();
			if (st !== o.status) begin
				$error("status: expected %0d, got %0d", o.status, st);
				errors++;
			end
			if (fv !== o.found_value) begin
				$error("found_value: expected %0d, got %0d", o.found_value, fv);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	lpht_pkg::action_t action;
	lpht_pkg::key_t    key;
	lpht_pkg::value_t  value;
	logic              rsp_valid;
	logic              rsp_stall;
	lpht_pkg::status_t status;
	lpht_pkg::value_t  found_value;

	probe_table_scoreboard sb = new();
	bit              calm = 1'b0;
	bit              long_hold = 1'b0;
	lpht_pkg::slot_t cluster_base;
	int              idle_cycles = 0;

	linear_probe_hash_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.key(key),
		.value(value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.found_value(found_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// keys mostly land in one cluster of home slots so probe chains grow
	function automatic lpht_pkg::key_t make_key();
		logic [HI_BITS-1:0] hi;
		lpht_pkg::slot_t home;
		hi = HI_BITS'($urandom);
		if ($urandom_range(0, 4) == 0)
			return lpht_pkg::key_t'($urandom);
		home = cluster_base + lpht_pkg::slot_t'($urandom_range(0, 40));
		return {hi, home};
	endfunction

	task automatic send_item(lpht_pkg::action_t a, lpht_pkg::key_t k, lpht_pkg::value_t v);
		@(negedge clk);
		req_valid <= 1'b1;
		action <= a;
		key <= k;
		value <= v;
		do @(posedge clk); while (req_stall !== 1'b0);
		sb.note_request(a, k, v);
	endtask

	task automatic idle_req(int n);
		if (n > 0) begin
			@(negedge clk) req_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk) req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	// receiver: random stall runs, plus one long hold-off on request
	initial begin
		int n;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				@(negedge clk) rsp_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (!calm) begin
				n = pick_gap();
				if (n > 0) begin
					@(negedge clk) rsp_stall <= 1'b1;
					repeat (n - 1) @(negedge clk);
				end
			end
			@(negedge clk) rsp_stall <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
			sb.check_outcome(status, found_value);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** linear_probe_hash_table: FAILED **");
			$finish;
		end
	end

	initial begin
		int r;
		lpht_pkg::key_t k;
		lpht_pkg::key_t live_keys[$];

		arst_n = 1'b0;
		req_valid = 1'b0;
		action = lpht_pkg::ACT_INSERT;
		key = '0;
		value = '0;
		cluster_base = lpht_pkg::slot_t'($urandom);
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// empty table, extremes, wrap from the last slot, duplicates, an unused action, clear
		send_item(lpht_pkg::ACT_FIND, '0, '0);
		send_item(lpht_pkg::ACT_INSERT, '0, '0);
		send_item(lpht_pkg::ACT_INSERT, {lpht_pkg::KEY_BITS{1'b1}},
			{lpht_pkg::VALUE_BITS{1'b1}});
		send_item(lpht_pkg::ACT_INSERT, lpht_pkg::key_t'(lpht_pkg::TABLE_SLOTS - 1),
			lpht_pkg::value_t'(1234));
		send_item(lpht_pkg::ACT_FIND, lpht_pkg::key_t'(lpht_pkg::TABLE_SLOTS - 1),
			{lpht_pkg::VALUE_BITS{1'b1}});
		send_item(lpht_pkg::ACT_FIND, {lpht_pkg::KEY_BITS{1'b1}}, '0);
		send_item(lpht_pkg::ACT_INSERT, '0, lpht_pkg::value_t'(5));
		send_item(lpht_pkg::ACT_FIND, '0, '0);
		send_item(ACT_UNUSED, {lpht_pkg::KEY_BITS{1'b1}}, {lpht_pkg::VALUE_BITS{1'b1}});
		send_item(lpht_pkg::ACT_FIND, lpht_pkg::key_t'(lpht_pkg::TABLE_SLOTS), '0);
		send_item(lpht_pkg::ACT_CLEAR, {lpht_pkg::KEY_BITS{1'b1}},
			{lpht_pkg::VALUE_BITS{1'b1}});
		send_item(lpht_pkg::ACT_FIND, '0, '0);
		send_item(lpht_pkg::ACT_FIND, {lpht_pkg::KEY_BITS{1'b1}}, '0);
		send_item(lpht_pkg::ACT_INSERT, '0, lpht_pkg::value_t'(123));
		send_item(lpht_pkg::ACT_FIND, '0, '0);
		send_item(lpht_pkg::ACT_CLEAR, '0, '0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (i == 900)
				long_hold = 1'b1;
			if (i == 1300)
				drain();
			if (!calm)
				idle_req(pick_gap());
			r = $urandom_range(0, 199);
			if (r < 2) begin
				live_keys.delete();
				cluster_base = ($urandom_range(0, 3) == 0)
					? lpht_pkg::slot_t'(lpht_pkg::TABLE_SLOTS - 12)
					: lpht_pkg::slot_t'($urandom);
				send_item(lpht_pkg::ACT_CLEAR, lpht_pkg::key_t'($urandom),
					lpht_pkg::value_t'($urandom));
			end else if (r < 6) begin
				send_item(ACT_UNUSED, make_key(), lpht_pkg::value_t'($urandom));
			end else if (r < 96) begin
				if (live_keys.size() != 0 && $urandom_range(0, 9) == 0)
					k = live_keys[$urandom_range(0, live_keys.size() - 1)];
				else
					k = make_key();
				live_keys.push_back(k);
				send_item(lpht_pkg::ACT_INSERT, k, lpht_pkg::value_t'($urandom));
			end else begin
				if (live_keys.size() != 0 && $urandom_range(0, 9) < 6)
					k = live_keys[$urandom_range(0, live_keys.size() - 1)];
				else
					k = make_key();
				send_item(lpht_pkg::ACT_FIND, k, lpht_pkg::value_t'($urandom));
			end
		end

		drain();
		repeat (64) @(posedge clk);
		if (sb.errors == 0)
			$display("** linear_probe_hash_table: PASSED **");
		else
			$display("** linear_probe_hash_table: FAILED **");
		$finish;
	end

endmodule

### filelist.f
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/linear_probe_hash_table.sv
tb/linear_probe_hash_table_test.sv
